// ----- hdl/median3x3_image_filter_core_assert.svh -----
// assertion helpers for the median filter core
`ifndef MEDIAN3X3_IMAGE_FILTER_CORE_ASSERT_SVH
`define MEDIAN3X3_IMAGE_FILTER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MED3_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define MED3_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/med3_pkg.sv -----
package med3_pkg;

  // default line store depth
  localparam int MAX_WIDTH_DEF = 1024;

  // fixed field widths
  localparam int PIX_W     = 8;
  localparam int ROW_W     = 16;
  localparam int OUT_COL_W = 10;
  localparam int CFG_W_W   = 11;
  localparam int CFG_H_W   = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  // register reset values
  localparam logic [CFG_W_W-1:0] CFG_W_RESET = 11'd1024;
  localparam logic [CFG_H_W-1:0] CFG_H_RESET = 16'd1024;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;
  typedef pix_t [8:0] win9_t;

  // one result item
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    pix_t                 value;
    logic                 last;
  } res_t;

  // stage 1 item info, column kept apart since its width follows the depth
  typedef struct packed {
    pix_t             pix;
    logic [ROW_W-1:0] row;
    logic             r_ge1;
    logic             r_ge2;
    logic             c_ge1;
    logic             c_ge2;
    logic             c_last;
    logic             r_last;
  } s1_t;

  // compare-exchange: {min, max}
  function automatic logic [2*PIX_W-1:0] sort2(input pix_t a, input pix_t b);
    return (a > b) ? {b, a} : {a, b};
  endfunction

  // fixed 19-element exchange network, median lands in slot 4
  function automatic pix_t median9(input win9_t v);
    win9_t p;
    p = v;
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[1]} = sort2(p[0], p[1]);
    {p[3], p[4]} = sort2(p[3], p[4]);
    {p[6], p[7]} = sort2(p[6], p[7]);
    {p[1], p[2]} = sort2(p[1], p[2]);
    {p[4], p[5]} = sort2(p[4], p[5]);
    {p[7], p[8]} = sort2(p[7], p[8]);
    {p[0], p[3]} = sort2(p[0], p[3]);
    {p[5], p[8]} = sort2(p[5], p[8]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[3], p[6]} = sort2(p[3], p[6]);
    {p[1], p[4]} = sort2(p[1], p[4]);
    {p[2], p[5]} = sort2(p[2], p[5]);
    {p[4], p[7]} = sort2(p[4], p[7]);
    {p[4], p[2]} = sort2(p[4], p[2]);
    {p[6], p[4]} = sort2(p[6], p[4]);
    {p[4], p[2]} = sort2(p[4], p[2]);
    return p[4];
  endfunction

endpackage

// ----- hdl/median3x3_image_filter_core.sv -----
// 3x3 median filter on a raster stream of 8-bit pixels. One pixel is taken per clock
// while stage 1 can move on; the line store read is registered with the pixel in
// stage 1, where the sorting network runs; when stage 1 moves on it writes the line
// store and loads the results into the output stage. A pixel yields zero to three
// results (a row comes out during the next row, the last row at once) and the single
// result port moves one per clock while out_ready is high, so input runs at one pixel
// per clock except at row ends and across the last row, where it follows the output.
// Border pixels pass through unchanged. The line store is two memories of MAX_WIDTH
// pixels; it needs no clearing after reset. Width and height are set through the cfg
// port while the block is idle, a rule for the user that the block does not enforce.
`include "median3x3_image_filter_core_assert.svh"

module median3x3_image_filter_core #(
  parameter int MAX_WIDTH = med3_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [med3_pkg::PIX_W-1:0]        in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [med3_pkg::ROW_W-1:0]        out_row,
  output logic [med3_pkg::OUT_COL_W-1:0]    out_col,
  output logic [med3_pkg::PIX_W-1:0]        out_value,
  output logic                              out_frame_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [med3_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [med3_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int WCMP = (WW > med3_pkg::CFG_W_W) ? WW : med3_pkg::CFG_W_W;
  localparam int RW   = med3_pkg::ROW_W;

  // configuration registers
  logic [med3_pkg::CFG_W_W-1:0] cfg_width_r;
  logic [med3_pkg::CFG_H_W-1:0] cfg_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= med3_pkg::CFG_W_RESET;
      cfg_height_r <= med3_pkg::CFG_H_RESET;
    end else if (cfg_valid) begin
      unique case (med3_pkg::cfg_idx_t'(cfg_index))
        med3_pkg::CFG_IMAGE_WIDTH: begin
          cfg_width_r <= cfg_data[med3_pkg::CFG_W_W-1:0];
        end
        med3_pkg::CFG_IMAGE_HEIGHT: begin
          cfg_height_r <= cfg_data[med3_pkg::CFG_H_W-1:0];
        end
      endcase
    end
  end

  // effective frame size
  logic [WCMP-1:0] cfg_w_ext;
  logic [WW-1:0]   w_eff;
  logic [RW-1:0]   h_eff;

  assign cfg_w_ext = WCMP'(cfg_width_r);

  always_comb begin
    if (cfg_w_ext < WCMP'(2)) begin
      w_eff = WW'(2);
    end else if (cfg_w_ext > WCMP'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_ext);
    end
    h_eff = (cfg_height_r < RW'(2)) ? RW'(2) : cfg_height_r;
  end

  // position of the next input pixel
  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic          pos_wrap;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [WW-1:0] col_inc;
  logic [RW:0]   row_inc;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;
  logic          cur_c_last;
  logic          cur_r_last;

  always_comb begin
    pos_wrap   = (WW'(col_r) >= w_eff) || (row_r >= h_eff);
    cur_col    = pos_wrap ? '0 : col_r;
    cur_row    = pos_wrap ? '0 : row_r;
    cur_c_last = (WW'(cur_col) == (w_eff - WW'(1)));
    cur_r_last = (cur_row == (h_eff - RW'(1)));
    col_inc    = WW'(cur_col) + WW'(1);
    row_inc    = {1'b0, cur_row} + (RW + 1)'(1);
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[RW-1:0];
    end else begin
      col_nxt = col_inc[CW-1:0];
      row_nxt = cur_row;
    end
  end

  // handshake signals
  logic           in_fire;
  logic           s1_valid_r;
  logic           s1_fire;
  logic           s1_load;
  logic [1:0]     cnt_r;
  logic           pop;

  assign in_ready = !s1_valid_r || s1_fire;
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign pop      = out_valid && out_ready;

  // stage 1 control and position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      col_r      <= '0;
      row_r      <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
        col_r      <= col_nxt;
        row_r      <= row_nxt;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // line store: row above and two rows above, one read and one write each
  med3_pkg::pix_t line0_mem [MAX_WIDTH];
  med3_pkg::pix_t line1_mem [MAX_WIDTH];

  med3_pkg::s1_t  s1_r;
  logic [CW-1:0]  s1_col_r;
  med3_pkg::pix_t top_r;
  med3_pkg::pix_t mid_r;

  // stage 1 payload with registered line store read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r.pix    <= in_pixel_value;
      s1_r.row    <= cur_row;
      s1_r.r_ge1  <= (cur_row >= RW'(1));
      s1_r.r_ge2  <= (cur_row >= RW'(2));
      s1_r.c_ge1  <= (cur_col >= CW'(1));
      s1_r.c_ge2  <= (cur_col >= CW'(2));
      s1_r.c_last <= cur_c_last;
      s1_r.r_last <= cur_r_last;
      s1_col_r    <= cur_col;
      top_r       <= line1_mem[cur_col];
      mid_r       <= line0_mem[cur_col];
    end
  end

  // line store write once the item leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line1_mem[s1_col_r] <= mid_r;
      line0_mem[s1_col_r] <= s1_r.pix;
    end
  end

  // two previous columns of the 3-row band
  med3_pkg::pix_t [5:0] win_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_fire) begin
      win_r[3] <= win_r[0];
      win_r[4] <= win_r[1];
      win_r[5] <= win_r[2];
      win_r[0] <= top_r;
      win_r[1] <= mid_r;
      win_r[2] <= s1_r.pix;
    end
  end

  // median and result building
  med3_pkg::win9_t     win9;
  med3_pkg::pix_t      med;
  med3_pkg::pix_t      prev_value;
  logic [CW-1:0]       col_m1;
  logic [RW-1:0]       row_m1;
  logic                has_prev;
  logic                has_edge;
  med3_pkg::res_t      res_prev;
  med3_pkg::res_t      res_edge;
  med3_pkg::res_t      res_self;
  med3_pkg::res_t [2:0] slot;
  logic [1:0]          n_res;

  always_comb begin
    win9 = {s1_r.pix, win_r[2], win_r[5], mid_r, win_r[1], win_r[4],
            top_r, win_r[0], win_r[3]};
    med        = med3_pkg::median9(win9);
    prev_value = (s1_r.r_ge2 && s1_r.c_ge2) ? med : win_r[1];
    col_m1     = s1_col_r - CW'(1);
    row_m1     = s1_r.row - RW'(1);
    has_prev   = s1_r.r_ge1 && s1_r.c_ge1;
    has_edge   = s1_r.r_ge1 && s1_r.c_last;

    res_prev.row   = row_m1;
    res_prev.col   = med3_pkg::OUT_COL_W'(col_m1);
    res_prev.value = prev_value;
    res_prev.last  = 1'b0;

    res_edge.row   = row_m1;
    res_edge.col   = med3_pkg::OUT_COL_W'(s1_col_r);
    res_edge.value = mid_r;
    res_edge.last  = 1'b0;

    res_self.row   = s1_r.row;
    res_self.col   = med3_pkg::OUT_COL_W'(s1_col_r);
    res_self.value = s1_r.pix;
    res_self.last  = s1_r.c_last;

    // pack present results in order
    slot  = '0;
    n_res = 2'd0;
    if (has_prev) begin
      slot[n_res] = res_prev;
      n_res       = n_res + 2'd1;
    end
    if (has_edge) begin
      slot[n_res] = res_edge;
      n_res       = n_res + 2'd1;
    end
    if (s1_r.r_last) begin
      slot[n_res] = res_self;
      n_res       = n_res + 2'd1;
    end
  end

  // stage 1 moves on when its results fit into the output stage
  assign s1_fire = s1_valid_r &&
                   ((n_res == 2'd0) || (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready));
  assign s1_load = s1_fire && (n_res != 2'd0);

  // output stage: up to three results, head goes out first
  med3_pkg::res_t [2:0] q_r;
  med3_pkg::res_t [2:0] q_nxt;
  logic [1:0]           cnt_nxt;

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (s1_load) begin
      q_nxt   = slot;
      cnt_nxt = n_res;
    end else if (pop) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_row        = q_r[0].row;
  assign out_col        = q_r[0].col;
  assign out_value      = q_r[0].value;
  assign out_frame_last = q_r[0].last;

  // checks
  `MED3_ASSERT_IMP(a_load_no_overwrite, s1_load, (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready), "results loaded over pending ones")
  `MED3_ASSERT_IMP(a_s1_no_overwrite, in_fire && s1_valid_r, s1_fire, "stage 1 item overwritten")
  `MED3_ASSERT_IMP(a_last_is_tail, out_valid && out_frame_last, cnt_r == 2'd1, "frame end not the last queued result")
  `MED3_ASSERT_NXT(a_load_shows, s1_load, out_valid, "loaded results not presented")

endmodule

// ----- dv/tb_median3x3_image_filter_core.sv -----
`timescale 1ns / 100ps

module tb_median3x3_image_filter_core;

  localparam int MAX_W      = med3_pkg::MAX_WIDTH_DEF;
  localparam int SETTLE_CYC = 16;
  localparam int CYCLE_CAP  = 100000;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [med3_pkg::PIX_W-1:0]      in_pixel_value = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [med3_pkg::ROW_W-1:0]      out_row;
  logic [med3_pkg::OUT_COL_W-1:0]  out_col;
  logic [med3_pkg::PIX_W-1:0]      out_value;
  logic                            out_frame_last;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [med3_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [med3_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  median3x3_image_filter_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel_value (in_pixel_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .out_frame_last (out_frame_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // filter image of the block: sizes, line rows, window and position
  logic [med3_pkg::CFG_W_W-1:0] img_w = med3_pkg::CFG_W_RESET;
  logic [med3_pkg::CFG_H_W-1:0] img_h = med3_pkg::CFG_H_RESET;
  med3_pkg::pix_t line_top [MAX_W] = '{default: '0};
  med3_pkg::pix_t line_mid [MAX_W] = '{default: '0};
  med3_pkg::pix_t band [6] = '{default: '0};
  int   pos_row = 0;
  int   pos_col = 0;

  med3_pkg::res_t filt_expect [$];
  int   mismatches = 0;
  int   cycles = 0;

  // idling controls, in percent per item or per cycle
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit stall_req = 1'b0;
  int stall_len = 0;

  // fifth smallest of nine
  function automatic med3_pkg::pix_t median_of_nine(input med3_pkg::pix_t nb [9]);
    med3_pkg::pix_t s [9];
    med3_pkg::pix_t t;
    s = nb;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8 - i; j++) begin
        if (s[j] > s[j+1]) begin
          t = s[j];
          s[j] = s[j+1];
          s[j+1] = t;
        end
      end
    end
    return s[4];
  endfunction

  function automatic med3_pkg::res_t make_res(input int r, input int c,
                                              input med3_pkg::pix_t v, input bit l);
    med3_pkg::res_t x;
    x.row   = r[med3_pkg::ROW_W-1:0];
    x.col   = c[med3_pkg::OUT_COL_W-1:0];
    x.value = v;
    x.last  = l;
    return x;
  endfunction

  // advance the filter image by one pixel and queue the results it causes
  task automatic filter_pixel(input med3_pkg::pix_t p);
    int   w, h, r, c;
    med3_pkg::pix_t top, mid, v;
    med3_pkg::pix_t nb [9];
    w = img_w;
    if (w < 2) w = 2;
    if (w > MAX_W) w = MAX_W;
    h = img_h;
    if (h < 2) h = 2;
    if (pos_col >= w || pos_row >= h) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    top = line_top[c];
    mid = line_mid[c];
    if (r >= 1 && c >= 1) begin
      if (r >= 2 && c >= 2) begin
        nb = '{band[3], band[0], top, band[4], band[1], mid, band[5], band[2], p};
        v = median_of_nine(nb);
      end else begin
        v = band[1];
      end
      filt_expect.push_back(make_res(r - 1, c - 1, v, 1'b0));
    end
    if (r >= 1 && c == w - 1) filt_expect.push_back(make_res(r - 1, c, mid, 1'b0));
    if (r == h - 1) filt_expect.push_back(make_res(r, c, p, c == w - 1));
    band[3] = band[0];
    band[4] = band[1];
    band[5] = band[2];
    band[0] = top;
    band[1] = mid;
    band[2] = p;
    line_top[c] = mid;
    line_mid[c] = p;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    pos_row = r;
    pos_col = c;
  endtask

  // result checker
  always @(posedge clk) begin
    med3_pkg::res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (filt_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result row %0d col %0d value %0d last %0b",
                   out_row, out_col, out_value, out_frame_last);
      end else begin
        want = filt_expect.pop_front();
        if (out_row !== want.row || out_col !== want.col ||
            out_value !== want.value || out_frame_last !== want.last) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result differs: exp row %0d col %0d value %0d last %0b",
                     want.row, want.col, want.value, want.last);
            $display("                got row %0d col %0d value %0d last %0b",
                     out_row, out_col, out_value, out_frame_last);
          end
        end
      end
    end
  end

  // receiver: random stalls plus an optional long hold-off
  int rx_gap = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (stall_req) begin
      stall_req = 1'b0;
      stall_left = stall_len;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_ready <= 1'b0;
    end else if (rx_idle_pct > 0 && $urandom_range(99) < rx_idle_pct) begin
      rx_gap = $urandom_range(15, 1) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_CAP) begin
      $display("median3x3_image_filter_core: mismatch");
      $finish;
    end
  end

  // send one pixel item; valid stays high into the next item unless a gap comes
  task automatic send_pixel(input med3_pkg::pix_t p);
    int gap;
    gap = 0;
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) gap = $urandom_range(15, 1);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= p;
    do @(posedge clk); while (!in_ready);
    filter_pixel(p);
    @(negedge clk);
  endtask

  task automatic write_reg(input med3_pkg::cfg_idx_t idx,
                           input logic [med3_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      med3_pkg::CFG_IMAGE_WIDTH:  img_w = data[med3_pkg::CFG_W_W-1:0];
      med3_pkg::CFG_IMAGE_HEIGHT: img_h = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // wait for every queued result, then let the pipeline settle
  task automatic settle();
    in_valid <= 1'b0;
    while (filt_expect.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // pixel mix: extremes, near-equal clusters for ties, and full range
  function automatic med3_pkg::pix_t pick_pixel();
    int k;
    k = $urandom_range(3);
    case (k)
      0: return $urandom_range(1) ? 8'hFF : 8'h00;
      1: return 8'(120 + $urandom_range(3));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel());
  endtask

  task automatic set_size(input int w, input int h);
    write_reg(med3_pkg::CFG_IMAGE_WIDTH, w[med3_pkg::CFG_DATA_W-1:0]);
    write_reg(med3_pkg::CFG_IMAGE_HEIGHT, h[med3_pkg::CFG_DATA_W-1:0]);
  endtask

  // reset sizes, then a width change that leaves the position outside the row
  task automatic test_reset_sizes();
    med3_pkg::pix_t seq [5] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01};
    foreach (seq[i]) send_pixel(seq[i]);
    settle();
    set_size(4, 2);
    for (int i = 0; i < 8; i++) send_pixel(8'(i * 37));
    settle();
  endtask

  // small frames with extremes and ties
  task automatic test_small_frames();
    med3_pkg::pix_t f3 [9] = '{8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'hFF,
                               8'h00};
    med3_pkg::pix_t f2 [4] = '{8'h00, 8'hFF, 8'hFF, 8'h00};
    set_size(3, 3);
    foreach (f3[i]) send_pixel(f3[i]);
    for (int i = 0; i < 9; i++) send_pixel(8'h07);
    settle();
    set_size(2, 2);
    foreach (f2[i]) send_pixel(f2[i]);
    settle();
  endtask

  // out-of-range register values and the start of the widest row
  task automatic test_register_limits();
    set_size(0, 1);
    send_random(4);
    settle();
    write_reg(med3_pkg::CFG_IMAGE_WIDTH, 16'd1);
    write_reg(med3_pkg::CFG_IMAGE_HEIGHT, 16'd0);
    send_random(4);
    settle();
    write_reg(med3_pkg::CFG_IMAGE_WIDTH, 16'hF803);
    write_reg(med3_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    send_random(9);
    settle();
    set_size(2047, 2);
    send_random(6);
    settle();
  endtask

  // tallest frame: a few rows, then a height change restarts the frame
  task automatic test_tall_frame();
    set_size(2, 65535);
    send_random(20);
    settle();
    write_reg(med3_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    send_random(6);
    settle();
  endtask

  // register writes mid-frame, inside and outside the current position
  task automatic test_midframe_writes();
    set_size(5, 4);
    send_random(7);
    settle();
    write_reg(med3_pkg::CFG_IMAGE_HEIGHT, 16'd3);
    send_random(8);
    settle();
    send_random(3);
    settle();
    write_reg(med3_pkg::CFG_IMAGE_WIDTH, 16'd2);
    send_random(4);
    settle();
  endtask

  // receiver holds off long while the sender keeps offering
  // one full 16-wide frame also fills every line column the random frames use
  task automatic test_backpressure();
    int keep_tx, keep_rx;
    keep_tx = tx_idle_pct;
    keep_rx = rx_idle_pct;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_size(16, 3);
    stall_len = 300;
    stall_req = 1'b1;
    send_random(48);
    settle();
    tx_idle_pct = keep_tx;
    rx_idle_pct = keep_rx;
  endtask

  // random frames, mostly complete, some cut short
  task automatic test_random_frames(input int target);
    int sent, w, h, n;
    sent = 0;
    while (sent < target) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(16, 10) : $urandom_range(9, 2);
      h = $urandom_range(6, 2);
      case ($urandom_range(9))
        0: set_size($urandom_range(1), h);
        1: set_size(w, $urandom_range(1));
        2: write_reg(med3_pkg::CFG_IMAGE_HEIGHT, h[med3_pkg::CFG_DATA_W-1:0]);
        default: set_size(w, h);
      endcase
      case ($urandom_range(2))
        0: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        1: begin tx_idle_pct = 10; rx_idle_pct = 10; end
        default: begin tx_idle_pct = 30; rx_idle_pct = 30; end
      endcase
      n = w * h;
      if (n < 4) n = 4;
      if ($urandom_range(99) < 15) n = $urandom_range(n - 1, 1);
      send_random(n);
      sent += n;
      settle();
    end
  endtask

  // closing stretch without any idling
  task automatic test_steady_stream();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_size(7, 3);
    send_random(21);
    settle();
    set_size(4, 5);
    send_random(20);
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    tx_idle_pct = 25;
    rx_idle_pct = 25;
    test_reset_sizes();
    test_small_frames();
    test_register_limits();
    test_tall_frame();
    test_midframe_writes();
    test_backpressure();
    test_random_frames(30);
    test_steady_stream();
    if (mismatches == 0 && filt_expect.size() == 0) begin
      $display("median3x3_image_filter_core: match");
    end else begin
      $display("median3x3_image_filter_core: mismatch");
    end
    $finish;
  end

endmodule
